[rtl/double_ended_queue_unit_defines.svh]
// assertion macros for the deque unit
// used by the top level only; expects clk and rst_n in scope
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/deq_pkg.sv]
// shared types and codes for the deque unit
// no dependencies
package deq_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] item_value;
  } deq_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  result_value;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } deq_out_t;

endpackage

[rtl/deq_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/double_ended_queue_unit.sv]
// deque kept as a ring in one ram, with front index and count in registers
// depends on deq_pkg, deq_ram and double_ended_queue_unit_defines.svh
//
//  channel | ports                              | moves
//  --------+------------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_data        | one operation per transfer
//  output  | out_valid, out_ready, out_data     | one result per operation
//
// push, clear, contains on empty and any pop/peek/push that hits empty or full: result loaded at the transfer
// pop and peek: ram read issued at the transfer, registered read data loaded as result in S_READ
// contains: words read from the front in S_SCAN until the first match, or to the back on a miss
// reset clears state, output valid, front index and count; the ram holds no reset state
// a new operation is taken only in idle and when the output register is free
// or its result is transferred in the same cycle
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_out_t out_data
);

  import deq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [IW:0]   DEPTH_X  = (IW+1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  // ring position of a + b, both below DEPTH
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IW-1:0];
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [IW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    scan_r, scan_nxt;
  logic [WIDTH-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  deq_out_t         out_data_r, out_data_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic [IW-1:0]    back_off;
  logic [CW-1:0]    count_dec;
  logic [WIDTH-1:0] key_in;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    rd_addr;
  logic [WIDTH-1:0] rd_data;
  logic             scan_hit;
  logic             scan_last;

  logic                res_load;
  logic [WIDTH-1:0]    res_val;
  logic                res_found;
  logic [STATUS_W-1:0] res_status;
  logic [CW+4:0]       count_ext;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign count_dec = count_r - 1'b1;
  assign back_off  = count_dec[IW-1:0];
  assign key_in    = WIDTH'(in_data.item_value);
  assign scan_hit  = (rd_data == key_r);
  assign scan_last = (scan_r == back_off);

  deq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    key_nxt    = key_r;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    rd_addr    = front_r;
    res_load   = 1'b0;
    res_val    = '0;
    res_found  = 1'b0;
    res_status = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_PUSH_FRONT: begin
              res_load = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                front_nxt = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
                wr_en     = 1'b1;
                wr_addr   = front_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              res_load = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ring_add(front_r, count_r[IW-1:0]);
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                rd_addr   = front_r;
                state_nxt = S_READ;
                if (in_data.operation == OP_POP_FRONT) begin
                  front_nxt = ring_add(front_r, IW'(1));
                  count_nxt = count_dec;
                end
              end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                rd_addr   = ring_add(front_r, back_off);
                state_nxt = S_READ;
                if (in_data.operation == OP_POP_BACK) begin
                  count_nxt = count_dec;
                end
              end
            end
            OP_CONTAINS: begin
              if (empty) begin
                res_load = 1'b1;
              end else begin
                rd_addr   = front_r;
                scan_nxt  = '0;
                key_nxt   = key_in;
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              res_load  = 1'b1;
              front_nxt = '0;
              count_nxt = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // state already moved at the transfer; only the word is left
        res_load  = 1'b1;
        res_val   = rd_data;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        // rd_data holds the word at offset scan_r from the front
        if (scan_hit || scan_last) begin
          res_load  = 1'b1;
          res_found = scan_hit;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
          rd_addr  = ring_add(front_r, scan_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_ext = {5'b0, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.result_value = VALUE_W'(res_val);
      out_data_nxt.found        = res_found;
      out_data_nxt.status       = res_status;
      out_data_nxt.count        = count_ext[COUNT_W-1:0];
      out_data_nxt.is_empty     = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT, "count above depth")
  `DEQ_ASSERT_NOW(a_front_bound, 1'b1, front_r <= LAST_IDX, "front index out of ring")
  `DEQ_ASSERT_NOW(a_busy_out_free, state_r != S_IDLE, !out_valid_r,
                  "result pending while operation in flight")
  `DEQ_ASSERT_NEXT(a_push_grows,
                   accept && !full && (in_data.operation == OP_PUSH_FRONT ||
                                       in_data.operation == OP_PUSH_BACK),
                   count_r == $past(count_r) + 1'b1, "push did not grow count")

endmodule
